/* rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assert that a implies b on the same edge
`define ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// assert that a implies b on the next edge
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

/* rtl/shdc_pkg.sv */
// ----------------------------------------------------------------------------
// shdc_pkg
// types, constants and codes for the salted hash dedup counter
// ----------------------------------------------------------------------------
package shdc_pkg;

  localparam int SET_DEPTH = 256;
  localparam int AW = $clog2(SET_DEPTH);
  localparam int FW = AW + 1;
  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_MUL = 64'h00000100000001b3;

  localparam logic [1:0] FUNC_SIGHT = 2'd0;
  localparam logic [1:0] FUNC_END = 2'd1;
  localparam logic [1:0] FUNC_ERR = 2'd2;
  localparam logic [1:0] FUNC_IGNORE = 2'd3;

  localparam logic [1:0] REG_SALT = 2'd0;
  localparam logic [1:0] REG_SPC = 2'd1;
  localparam logic [1:0] REG_MPS = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [47:0] station_addr;
  } in_item_t;

  typedef struct packed {
    logic [63:0] hash_value;
    logic repeated;
    logic new_overall;
    logic store_full;
    logic report_valid;
    logic [15:0] cycle_impressions;
    logic [15:0] cycle_unique;
    logic [15:0] cycle_repeated;
    logic [31:0] total_unique;
    logic [31:0] total_scans;
    logic [31:0] scan_error_count;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECIDE, ST_HASH, ST_MUL, ST_CUR_RD, ST_CUR_CMP, ST_INSERT,
    ST_PREV_RD, ST_PREV_CMP, ST_SIGHT_DONE, ST_SCAN, ST_OUT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic hash_xor;
    logic hash_mul;
    logic rd_cur;
    logic rd_prev;
    logic idx_clr;
    logic idx_inc;
    logic note_rep;
    logic insert;
    logic note_new;
    logic sight_done;
    logic skip_sight;
    logic scan_done;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_sight;
    logic is_scan;
    logic over_limit;
    logic last_byte;
    logic idx_end_cur;
    logic idx_end_prev;
    logic match;
  } stat_t;

endpackage

/* rtl/shdc_ctrl.sv */
// ----------------------------------------------------------------------------
// shdc_ctrl
// sequencer: hash rounds, bank walks, scan bookkeeping
// ----------------------------------------------------------------------------
module shdc_ctrl import shdc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state, state_next;
  logic busy;
  logic ov, ov_next;

  // state and output flag registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ov <= 1'b0;
    end else begin
      state <= state_next;
      ov <= ov_next;
    end
  end

  // a waiting result blocks the next item until it is taken
  assign busy = (state != ST_IDLE);
  assign out_valid = ov;
  assign in_stall = busy || (ov && out_stall);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    ov_next = ov && out_stall;
    case (state)
      ST_IDLE: begin
        if (in_valid && !(ov && out_stall)) begin
          cmd.load = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (st.is_sight) begin
          if (st.over_limit) begin
            cmd.skip_sight = 1'b1;
            state_next = ST_OUT;
          end else state_next = ST_HASH;
        end else if (st.is_scan) begin
          state_next = ST_SCAN;
        end else state_next = ST_OUT;
      end
      ST_HASH: begin
        cmd.hash_xor = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.hash_mul = 1'b1;
        if (st.last_byte) begin
          cmd.idx_clr = 1'b1;
          state_next = ST_CUR_RD;
        end else state_next = ST_HASH;
      end
      ST_CUR_RD: begin
        if (st.idx_end_cur) begin
          cmd.insert = 1'b1;
          cmd.idx_clr = 1'b1;
          state_next = ST_PREV_RD;
        end else begin
          cmd.rd_cur = 1'b1;
          state_next = ST_CUR_CMP;
        end
      end
      ST_CUR_CMP: begin
        if (st.match) begin
          cmd.note_rep = 1'b1;
          state_next = ST_SIGHT_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next = ST_CUR_RD;
        end
      end
      ST_PREV_RD: begin
        if (st.idx_end_prev) begin
          cmd.note_new = 1'b1;
          state_next = ST_SIGHT_DONE;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next = ST_PREV_CMP;
        end
      end
      ST_PREV_CMP: begin
        if (st.match) state_next = ST_SIGHT_DONE;
        else begin
          cmd.idx_inc = 1'b1;
          state_next = ST_PREV_RD;
        end
      end
      ST_SIGHT_DONE: begin
        cmd.sight_done = 1'b1;
        state_next = ST_OUT;
      end
      ST_SCAN: begin
        cmd.scan_done = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!(ov && out_stall)) begin
          ov_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* rtl/shdc_dp.sv */
// ----------------------------------------------------------------------------
// shdc_dp
// hash unit, two hash banks, counters and result register
// ----------------------------------------------------------------------------
module shdc_dp import shdc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  in_item_t   in_item,
  input  cmd_t       cmd,
  output stat_t      st,
  output out_item_t  out_item
);

  logic [63:0] bank_a [SET_DEPTH];
  logic [63:0] bank_b [SET_DEPTH];

  logic [31:0] salt;
  logic [7:0] spc, mps;
  logic cur_b;
  logic [FW-1:0] cur_fill, prev_fill, idx;
  logic [7:0] pos, scans;
  logic [15:0] imp_acc, uni_acc, rep_acc;
  logic [31:0] uni_tot, scan_tot, err_tot;
  in_item_t item;
  logic [79:0] bytes;
  logic [3:0] bcnt;
  logic [63:0] h, rd;
  logic rep, nov, full;
  logic [7:0] scans_n;
  logic rep_flag;

  function automatic logic [15:0] sat16(input logic [15:0] v);
    return (v == 16'hffff) ? v : v + 16'd1;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      salt <= '0;
      spc <= 8'd10;
      mps <= 8'd20;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SALT: salt <= cfg_data;
        REG_SPC: spc <= cfg_data[7:0];
        REG_MPS: mps <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // bank reads and inserts
  always_ff @(posedge clk) begin
    if (cmd.rd_cur) rd <= cur_b ? bank_b[idx[AW-1:0]] : bank_a[idx[AW-1:0]];
    else if (cmd.rd_prev) rd <= cur_b ? bank_a[idx[AW-1:0]] : bank_b[idx[AW-1:0]];
    if (cmd.insert && cur_fill < FW'(SET_DEPTH)) begin
      if (cur_b) bank_b[cur_fill[AW-1:0]] <= h;
      else bank_a[cur_fill[AW-1:0]] <= h;
    end
  end

  // item, hash unit and flags
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_item;
      bytes <= {in_item.station_addr, salt[7:0], salt[15:8], salt[23:16], salt[31:24]};
      bcnt <= '0;
      h <= FNV_BASIS;
      rep <= 1'b0;
      nov <= 1'b0;
      full <= 1'b0;
    end
    if (cmd.hash_xor) begin
      h <= h ^ {56'd0, bytes[79:72]};
      bytes <= {bytes[71:0], 8'd0};
    end
    // multiply by the fnv prime 2^40 + 0x1b3 as shifts and adds
    if (cmd.hash_mul) begin
      h <= h + (h << 1) + (h << 4) + (h << 5) + (h << 7) + (h << 8) + (h << 40);
      bcnt <= bcnt + 4'd1;
    end
    if (cmd.idx_clr) idx <= '0;
    if (cmd.idx_inc) idx <= idx + FW'(1);
    if (cmd.note_rep) rep <= 1'b1;
    if (cmd.note_new) nov <= 1'b1;
    if (cmd.insert) full <= (cur_fill >= FW'(SET_DEPTH));
  end

  // scan count after this mark, and whether it closes the cycle
  assign scans_n = (scans == 8'hff) ? scans : scans + 8'd1;
  assign rep_flag = scans_n >= spc;

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_b <= 1'b0;
      cur_fill <= '0;
      prev_fill <= '0;
      pos <= '0;
      scans <= '0;
      imp_acc <= '0;
      uni_acc <= '0;
      rep_acc <= '0;
      uni_tot <= '0;
      scan_tot <= '0;
      err_tot <= '0;
    end else begin
      if (cmd.skip_sight) imp_acc <= sat16(imp_acc);
      if (cmd.sight_done) begin
        imp_acc <= sat16(imp_acc);
        if (pos != 8'hff) pos <= pos + 8'd1;
        if (rep) rep_acc <= sat16(rep_acc);
        else uni_acc <= sat16(uni_acc);
        if (nov) uni_tot <= uni_tot + 32'd1;
      end
      if (cmd.insert && cur_fill < FW'(SET_DEPTH)) cur_fill <= cur_fill + FW'(1);
      if (cmd.scan_done) begin
        scan_tot <= scan_tot + 32'd1;
        if (item.func == FUNC_ERR) err_tot <= err_tot + 32'd1;
        pos <= '0;
        if (rep_flag) begin
          cur_b <= ~cur_b;
          prev_fill <= cur_fill;
          cur_fill <= '0;
          imp_acc <= '0;
          uni_acc <= '0;
          rep_acc <= '0;
          scans <= '0;
        end else scans <= scans_n;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load) out_item <= '0;
    if (cmd.sight_done) begin
      out_item.hash_value <= h;
      out_item.repeated <= rep;
      out_item.new_overall <= nov;
      out_item.store_full <= full;
    end
    if (cmd.scan_done && rep_flag) begin
      out_item.report_valid <= 1'b1;
      out_item.cycle_impressions <= imp_acc;
      out_item.cycle_unique <= uni_acc;
      out_item.cycle_repeated <= rep_acc;
      out_item.total_unique <= uni_tot;
      out_item.total_scans <= scan_tot + 32'd1;
      out_item.scan_error_count <= err_tot + ((item.func == FUNC_ERR) ? 32'd1 : 32'd0);
    end
  end

  // status
  assign st.is_sight = (item.func == FUNC_SIGHT);
  assign st.is_scan = (item.func == FUNC_END) || (item.func == FUNC_ERR);
  assign st.over_limit = (pos >= mps);
  assign st.last_byte = (bcnt == 4'd9);
  assign st.idx_end_cur = (idx >= cur_fill);
  assign st.idx_end_prev = (idx >= prev_fill);
  assign st.match = (rd == h);

endmodule

/* rtl/salted_hash_dedup_counter_core.sv */
// ----------------------------------------------------------------------------
// salted_hash_dedup_counter_core
// salted fnv-1a hash dedup over two swapping sets, with cycle reports
// ----------------------------------------------------------------------------
// channel  direction  payload     handshake
// in       input      in_item_t   in_valid / in_stall
// out      output     out_item_t  out_valid / out_stall
// cfg      input      32-bit      cfg_we, cfg_index
//
// one item at a time; a hashed sighting runs ten xor/multiply rounds,
// then one read and compare per bank entry (up to 2 * 256).
// synchronous reset; banks need no clearing, fill counts bound all reads.
// a result waits in the output register while out_stall is high, and the
// input stalls until it is taken.
module salted_hash_dedup_counter_core import shdc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item
);

  cmd_t cmd;
  stat_t st;

  shdc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .st(st), .cmd(cmd)
  );

  shdc_dp u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_item(in_item), .cmd(cmd), .st(st),
    .out_item(out_item)
  );

endmodule

/* rtl/shdc_checker.sv */
// ----------------------------------------------------------------------------
// shdc_checker
// port-level checks for the dedup counter
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module shdc_checker import shdc_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // an accepted item blocks further input next cycle
  `ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && !in_stall, in_stall)
  // a stalled result holds
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_item))
  // report fields are zero unless a report is flagged
  `ASSERT_IMP(a_rep_zero, clk, rst, out_valid && !out_item.report_valid,
    out_item.total_scans == 32'd0)
  // a repeat is never new overall
  `ASSERT_IMP(a_rep_new, clk, rst, out_valid && out_item.repeated, !out_item.new_overall)

endmodule

bind salted_hash_dedup_counter_core shdc_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
);
